### hdl/tme_pkg.sv
`timescale 1ns / 1ps

package tme_pkg;

	// default sizes of the machine
	localparam int IMEM_WORDS_DEF = 512;
	localparam int DATA_WORDS_DEF = 16;
	localparam int REG_COUNT_DEF  = 8;

	// field widths of one item
	localparam int OPC_W   = 4;
	localparam int RIDX_W  = 3;
	localparam int OPZ_W   = 9;
	localparam int WORD_W  = 32;
	localparam int NPC_W   = 9;
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 48;

	// opcodes
	localparam logic [OPC_W-1:0] OP_LOAD   = 4'd1;
	localparam logic [OPC_W-1:0] OP_ADD    = 4'd2;
	localparam logic [OPC_W-1:0] OP_STORE  = 4'd3;
	localparam logic [OPC_W-1:0] OP_SUB    = 4'd4;
	localparam logic [OPC_W-1:0] OP_INPUT  = 4'd5;
	localparam logic [OPC_W-1:0] OP_OUTPUT = 4'd6;
	localparam logic [OPC_W-1:0] OP_HALT   = 4'd7;
	localparam logic [OPC_W-1:0] OP_JUMP   = 4'd8;
	localparam logic [OPC_W-1:0] OP_SKIP   = 4'd9;

	// register that comes out of reset holding one
	localparam int REG_ONE_IDX = 6;

	// pc steps
	localparam int PC_STEP      = 4;
	localparam int PC_STEP_SKIP = 8;

	// reciprocal scale, exact quotients of 9-bit values for divisors up to 2^16
	localparam int RECIP_SH = 26;

	// control from the execute logic
	typedef struct packed {
		logic reg_we;
		logic mem_we;
		logic out_valid;
		logic halt;
	} exec_ctl_t;

	// remainder of a 9-bit value by a constant, reciprocal multiply and one subtract
	function automatic logic [OPZ_W-1:0] mod9(input logic [OPZ_W-1:0] v, input int d);
		logic [63:0] recip;
		logic [63:0] quot;
		logic [63:0] rem;
		recip = ((64'd1 << RECIP_SH) + 64'(d) - 64'd1) / 64'(d);
		quot  = (64'(v) * recip) >> RECIP_SH;
		rem   = 64'(v) - quot * 64'(d);
		return rem[OPZ_W-1:0];
	endfunction

	// reset contents of one register
	function automatic logic [WORD_W-1:0] reg_reset_val(input logic [31:0] idx, input int cnt);
		logic [WORD_W-1:0] v;
		v = '0;
		if ((REG_ONE_IDX < cnt) && (idx == 32'(REG_ONE_IDX))) begin
			v = WORD_W'(1);
		end
		return v;
	endfunction

endpackage

### hdl/tme_ram.sv
`timescale 1ns / 1ps

module tme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// two registered read ports, old data on a same-cycle write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

### hdl/tme_exec.sv
`timescale 1ns / 1ps

module tme_exec #(
	parameter int IMEM_WORDS = tme_pkg::IMEM_WORDS_DEF,
	parameter int DATA_WORDS = tme_pkg::DATA_WORDS_DEF,
	parameter int REG_COUNT  = tme_pkg::REG_COUNT_DEF
) (
	input  logic [tme_pkg::OPC_W-1:0]     op,
	input  logic [$clog2(REG_COUNT)-1:0]  rx_idx,
	input  logic [tme_pkg::OPZ_W-1:0]     opz,
	input  logic [$clog2(DATA_WORDS)-1:0] addr,
	input  logic [tme_pkg::WORD_W-1:0]    in_value,
	input  logic [tme_pkg::WORD_W-1:0]    opnd_a,
	input  logic [tme_pkg::WORD_W-1:0]    opnd_b,
	input  logic [tme_pkg::WORD_W-1:0]    mem_rd,
	input  logic [$clog2(IMEM_WORDS)-1:0] pc,
	input  logic                          halted_in,
	output tme_pkg::exec_ctl_t            ctl,
	output logic [$clog2(REG_COUNT)-1:0]  reg_widx,
	output logic [tme_pkg::WORD_W-1:0]    reg_wdata,
	output logic [$clog2(DATA_WORDS)-1:0] mem_waddr,
	output logic [tme_pkg::WORD_W-1:0]    mem_wdata,
	output logic [$clog2(IMEM_WORDS)-1:0] pc_next,
	output logic [tme_pkg::WORD_W-1:0]    out_value
);

	localparam int PC_W = $clog2(IMEM_WORDS);

	logic [16:0]              pc_sum;
	logic [16:0]              pc_wrap;
	logic [PC_W-1:0]          pc_adv4;
	logic [PC_W-1:0]          pc_adv8;
	logic [PC_W-1:0]          pc_jump;
	logic [tme_pkg::OPZ_W-1:0] jmp_mod;
	logic [15:0]              jmp_ext;

	// pc plus a step, wrapped at the instruction memory size
	always_comb begin
		pc_sum  = 17'(pc) + 17'(tme_pkg::PC_STEP);
		pc_wrap = 17'(pc) + 17'(tme_pkg::PC_STEP_SKIP);
		if (pc_sum >= 17'(IMEM_WORDS)) begin
			pc_sum = pc_sum - 17'(IMEM_WORDS);
		end
		if (pc_wrap >= 17'(IMEM_WORDS)) begin
			pc_wrap = pc_wrap - 17'(IMEM_WORDS);
		end
		pc_adv4 = pc_sum[PC_W-1:0];
		pc_adv8 = pc_wrap[PC_W-1:0];
	end

	// jump target aligned down to a word
	always_comb begin
		jmp_mod = tme_pkg::mod9(opz & ~tme_pkg::OPZ_W'(3), IMEM_WORDS);
		jmp_ext = 16'(jmp_mod);
		pc_jump = jmp_ext[PC_W-1:0];
	end

	// instruction decode and effects
	always_comb begin
		ctl       = '0;
		reg_widx  = rx_idx;
		reg_wdata = in_value;
		mem_waddr = addr;
		mem_wdata = opnd_a;
		out_value = '0;
		pc_next   = pc_adv4;
		if (halted_in) begin
			ctl.halt = 1'b1;
			pc_next  = pc;
		end else begin
			unique case (op)
				tme_pkg::OP_LOAD: begin
					ctl.reg_we = 1'b1;
					reg_wdata  = mem_rd;
				end
				tme_pkg::OP_ADD: begin
					ctl.reg_we = 1'b1;
					reg_wdata  = opnd_a + opnd_b;
				end
				tme_pkg::OP_STORE: begin
					ctl.mem_we = 1'b1;
				end
				tme_pkg::OP_SUB: begin
					ctl.reg_we = 1'b1;
					reg_wdata  = opnd_a - opnd_b;
				end
				tme_pkg::OP_INPUT: begin
					ctl.reg_we = 1'b1;
				end
				tme_pkg::OP_OUTPUT: begin
					ctl.out_valid = 1'b1;
					out_value     = opnd_a;
				end
				tme_pkg::OP_HALT: begin
					ctl.halt = 1'b1;
					pc_next  = pc;
				end
				tme_pkg::OP_JUMP: begin
					pc_next = pc_jump;
				end
				tme_pkg::OP_SKIP: begin
					if (opnd_a == '0) begin
						pc_next = pc_adv8;
					end
				end
				default: begin
					pc_next = pc_adv4;
				end
			endcase
		end
	end

endmodule

### hdl/tiny_machine_execute_unit.sv
`timescale 1ns / 1ps

// channel   dir   handshake            payload
// s_axis    in    s_tvalid/s_tready    s_tdata: opcode, reg_x, reg_y, operand_z, in_value
// m_axis    out   m_tvalid/m_tready    m_tdata: next_pc, out_value, halted; m_tuser: out_valid
//
// one instruction per cycle while no full result waits on m_tready: operands are read
// from the register file and data memory rams when the item enters the input register,
// then execute and the state writes complete as the result register loads.
// the result register parts the two sides, so a full result waiting on m_tready
// stalls only the input register; results keep input order.
// arst_n clears the pc, the halt flag and the per-entry valid bits at once;
// an entry not yet written reads as its reset value.

module tiny_machine_execute_unit #(
	parameter int IMEM_WORDS = tme_pkg::IMEM_WORDS_DEF,
	parameter int DATA_WORDS = tme_pkg::DATA_WORDS_DEF,
	parameter int REG_COUNT  = tme_pkg::REG_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// opcode[3:0], reg_x[6:4], reg_y[9:7], operand_z[18:10], in_value[50:19], zero pad
	input  logic [tme_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// next_pc[8:0], out_value[40:9], halted[41], zero pad
	output logic [tme_pkg::M_TDATA_W-1:0]   m_tdata,
	// out_valid[0]
	output logic [0:0]                      m_tuser
);

	localparam int PC_W = $clog2(IMEM_WORDS);
	localparam int RI_W = $clog2(REG_COUNT);
	localparam int DA_W = $clog2(DATA_WORDS);
	localparam int W    = tme_pkg::WORD_W;

	// incoming fields
	logic [tme_pkg::OPC_W-1:0]  in_op;
	logic [tme_pkg::RIDX_W-1:0] in_x;
	logic [tme_pkg::RIDX_W-1:0] in_y;
	logic [tme_pkg::OPZ_W-1:0]  in_z;
	logic [W-1:0]               in_val;
	logic [15:0]                rx_ext;
	logic [15:0]                ry_ext;
	logic [15:0]                rz_ext;
	logic [15:0]                ad_ext;
	logic [RI_W-1:0]            in_rx;
	logic [RI_W-1:0]            in_ry;
	logic [RI_W-1:0]            in_rz;
	logic [DA_W-1:0]            in_addr;
	logic [RI_W-1:0]            raddr_a;

	// handshake
	logic accept;
	logic fire;

	// input register
	logic                      s1_valid_q;
	logic [tme_pkg::OPC_W-1:0] op_s1;
	logic [RI_W-1:0]           rx_s1;
	logic [tme_pkg::OPZ_W-1:0] z_s1;
	logic [DA_W-1:0]           addr_s1;
	logic [W-1:0]              in_value_s1;
	logic                      a_byp_s1;
	logic [W-1:0]              a_bdata_s1;
	logic                      b_byp_s1;
	logic [W-1:0]              b_bdata_s1;
	logic                      m_byp_s1;
	logic [W-1:0]              m_bdata_s1;

	// bypass decisions at accept
	logic                      fwd_a;
	logic                      fwd_b;
	logic                      fwd_m;

	// architectural state
	logic [PC_W-1:0]           pc_q;
	logic                      halt_q;
	logic [REG_COUNT-1:0]      reg_vld_q;
	logic [DATA_WORDS-1:0]     mem_vld_q;

	// ram data
	logic [W-1:0]              rf_rd_a;
	logic [W-1:0]              rf_rd_b;
	logic [W-1:0]              dm_rd;

	// execute outputs
	tme_pkg::exec_ctl_t        ctl;
	logic [RI_W-1:0]           reg_widx;
	logic [W-1:0]              reg_wdata;
	logic [DA_W-1:0]           mem_waddr;
	logic [W-1:0]              mem_wdata;
	logic [PC_W-1:0]           pc_next;
	logic [W-1:0]              out_value;
	logic [W-1:0]              opnd_a;
	logic [W-1:0]              opnd_b;
	logic [W-1:0]              mem_rd;
	logic [31:0]               pc_ext;

	// result register
	logic                      m_valid_q;
	logic [tme_pkg::NPC_W-1:0] res_pc_q;
	logic                      res_ov_q;
	logic [W-1:0]              res_val_q;
	logic                      res_halt_q;

	// field unpacking and index reduction
	always_comb begin
		in_op   = s_tdata[3:0];
		in_x    = s_tdata[6:4];
		in_y    = s_tdata[9:7];
		in_z    = s_tdata[18:10];
		in_val  = s_tdata[50:19];
		rx_ext  = 16'(tme_pkg::mod9(tme_pkg::OPZ_W'(in_x), REG_COUNT));
		ry_ext  = 16'(tme_pkg::mod9(tme_pkg::OPZ_W'(in_y), REG_COUNT));
		rz_ext  = 16'(tme_pkg::mod9(in_z, REG_COUNT));
		ad_ext  = 16'(tme_pkg::mod9(in_z, DATA_WORDS));
		in_rx   = rx_ext[RI_W-1:0];
		in_ry   = ry_ext[RI_W-1:0];
		in_rz   = rz_ext[RI_W-1:0];
		in_addr = ad_ext[DA_W-1:0];
	end

	// first register read port: source of store and output, r0 for skip, reg_y otherwise
	always_comb begin
		if (in_op == tme_pkg::OP_STORE || in_op == tme_pkg::OP_OUTPUT) begin
			raddr_a = in_rx;
		end else if (in_op == tme_pkg::OP_SKIP) begin
			raddr_a = '0;
		end else begin
			raddr_a = in_ry;
		end
	end

	// handshake
	assign fire     = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || fire;
	assign accept   = s_tvalid && s_tready;

	// forward writes of the executing item to the item now read
	always_comb begin
		fwd_a = fire && ctl.reg_we && (reg_widx == raddr_a);
		fwd_b = fire && ctl.reg_we && (reg_widx == in_rz);
		fwd_m = fire && ctl.mem_we && (mem_waddr == in_addr);
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	// input register payload and bypass data
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= in_op;
			rx_s1       <= in_rx;
			z_s1        <= in_z;
			addr_s1     <= in_addr;
			in_value_s1 <= in_val;
			a_byp_s1    <= fwd_a || !reg_vld_q[raddr_a];
			a_bdata_s1  <= fwd_a ? reg_wdata :
				tme_pkg::reg_reset_val(32'(raddr_a), REG_COUNT);
			b_byp_s1    <= fwd_b || !reg_vld_q[in_rz];
			b_bdata_s1  <= fwd_b ? reg_wdata :
				tme_pkg::reg_reset_val(32'(in_rz), REG_COUNT);
			m_byp_s1    <= fwd_m || !mem_vld_q[in_addr];
			m_bdata_s1  <= fwd_m ? mem_wdata : '0;
		end
	end

	// register file
	tme_ram #(
		.WIDTH (W),
		.DEPTH (REG_COUNT)
	) u_regfile (
		.clk     (clk),
		.we      (fire && ctl.reg_we),
		.waddr   (reg_widx),
		.wdata   (reg_wdata),
		.re      (accept),
		.raddr_a (raddr_a),
		.raddr_b (in_rz),
		.rdata_a (rf_rd_a),
		.rdata_b (rf_rd_b)
	);

	// data memory
	tme_ram #(
		.WIDTH (W),
		.DEPTH (DATA_WORDS)
	) u_datamem (
		.clk     (clk),
		.we      (fire && ctl.mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (accept),
		.raddr_a (in_addr),
		.raddr_b (in_addr),
		.rdata_a (dm_rd),
		.rdata_b ()
	);

	// operand select
	always_comb begin
		opnd_a = a_byp_s1 ? a_bdata_s1 : rf_rd_a;
		opnd_b = b_byp_s1 ? b_bdata_s1 : rf_rd_b;
		mem_rd = m_byp_s1 ? m_bdata_s1 : dm_rd;
	end

	// execute
	tme_exec #(
		.IMEM_WORDS (IMEM_WORDS),
		.DATA_WORDS (DATA_WORDS),
		.REG_COUNT  (REG_COUNT)
	) u_exec (
		.op        (op_s1),
		.rx_idx    (rx_s1),
		.opz       (z_s1),
		.addr      (addr_s1),
		.in_value  (in_value_s1),
		.opnd_a    (opnd_a),
		.opnd_b    (opnd_b),
		.mem_rd    (mem_rd),
		.pc        (pc_q),
		.halted_in (halt_q),
		.ctl       (ctl),
		.reg_widx  (reg_widx),
		.reg_wdata (reg_wdata),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.pc_next   (pc_next),
		.out_value (out_value)
	);

	// pc, halt flag and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			halt_q    <= 1'b0;
			reg_vld_q <= '0;
			mem_vld_q <= '0;
		end else if (fire) begin
			pc_q   <= pc_next;
			halt_q <= ctl.halt;
			if (ctl.reg_we) begin
				reg_vld_q[reg_widx] <= 1'b1;
			end
			if (ctl.mem_we) begin
				mem_vld_q[mem_waddr] <= 1'b1;
			end
		end
	end

	assign pc_ext = 32'(pc_next);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_pc_q   <= pc_ext[tme_pkg::NPC_W-1:0];
			res_ov_q   <= ctl.out_valid;
			res_val_q  <= out_value;
			res_halt_q <= ctl.halt;
		end
	end

	// output packing
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, res_halt_q, res_val_q, res_pc_q};
	assign m_tuser  = res_ov_q;

endmodule

### verif/tb_tiny_machine_execute_unit.sv
`timescale 1ns / 1ps

module tb_tiny_machine_execute_unit;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 5;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 4;
	localparam int RANDOM_ITEMS = 940;

	// opcodes outside the instruction set
	localparam logic [tme_pkg::OPC_W-1:0] OP_UNUSED_ZERO  = 4'd0;
	localparam logic [tme_pkg::OPC_W-1:0] OP_UNUSED_FIRST = 4'd10;
	localparam logic [tme_pkg::OPC_W-1:0] OP_UNUSED_LAST  = 4'd15;

	localparam logic [tme_pkg::WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
	localparam logic [tme_pkg::WORD_W-1:0] WORD_MIN = 32'h8000_0000;
	localparam logic [tme_pkg::WORD_W-1:0] WORD_ONES = 32'hffff_ffff;

	typedef struct {
		logic [tme_pkg::OPC_W-1:0]  opcode;
		logic [tme_pkg::RIDX_W-1:0] reg_x;
		logic [tme_pkg::RIDX_W-1:0] reg_y;
		logic [tme_pkg::OPZ_W-1:0]  operand_z;
		logic [tme_pkg::WORD_W-1:0] in_value;
	} instr_t;

	typedef struct {
		logic [tme_pkg::NPC_W-1:0]  next_pc;
		logic                       out_valid;
		logic [tme_pkg::WORD_W-1:0] out_value;
		logic                       halted;
	} exec_result_t;

	typedef enum {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [tme_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [tme_pkg::M_TDATA_W-1:0] m_tdata;
	logic [0:0]                    m_tuser;

	// machine state as predicted
	logic [tme_pkg::NPC_W-1:0]  mach_pc;
	logic [tme_pkg::WORD_W-1:0] mach_regs [tme_pkg::REG_COUNT_DEF];
	logic [tme_pkg::WORD_W-1:0] mach_dmem [tme_pkg::DATA_WORDS_DEF];
	logic                       mach_halted;

	exec_result_t pending_results [$];
	int           fail_count = 0;
	int           cycle_count = 0;
	int           burst_left = 0;
	bit           sender_gaps_off = 1'b0;
	int           rx_hold = 0;
	int           rx_phase_left = 0;
	rx_mode_t     rx_mode = RX_STREAM;

	tiny_machine_execute_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	// machine state after reset
	task automatic reset_machine();
		mach_pc = '0;
		mach_halted = 1'b0;
		foreach (mach_regs[i]) begin
			mach_regs[i] = (i == tme_pkg::REG_ONE_IDX) ? tme_pkg::WORD_W'(1) : '0;
		end
		foreach (mach_dmem[i]) begin
			mach_dmem[i] = '0;
		end
	endtask

	// execute one instruction on the predicted machine
	function automatic exec_result_t execute_instr(input instr_t it);
		exec_result_t               r;
		logic [3:0]                 addr;
		logic [tme_pkg::RIDX_W-1:0] rz;
		addr = it.operand_z[3:0];
		rz = it.operand_z[tme_pkg::RIDX_W-1:0];
		r.out_valid = 1'b0;
		r.out_value = '0;
		if (!mach_halted) begin
			case (it.opcode)
				tme_pkg::OP_LOAD: begin
					mach_regs[it.reg_x] = mach_dmem[addr];
					mach_pc = mach_pc + tme_pkg::NPC_W'(tme_pkg::PC_STEP);
				end
				tme_pkg::OP_ADD: begin
					mach_regs[it.reg_x] = mach_regs[it.reg_y] + mach_regs[rz];
					mach_pc = mach_pc + tme_pkg::NPC_W'(tme_pkg::PC_STEP);
				end
				tme_pkg::OP_STORE: begin
					mach_dmem[addr] = mach_regs[it.reg_x];
					mach_pc = mach_pc + tme_pkg::NPC_W'(tme_pkg::PC_STEP);
				end
				tme_pkg::OP_SUB: begin
					mach_regs[it.reg_x] = mach_regs[it.reg_y] - mach_regs[rz];
					mach_pc = mach_pc + tme_pkg::NPC_W'(tme_pkg::PC_STEP);
				end
				tme_pkg::OP_INPUT: begin
					mach_regs[it.reg_x] = it.in_value;
					mach_pc = mach_pc + tme_pkg::NPC_W'(tme_pkg::PC_STEP);
				end
				tme_pkg::OP_OUTPUT: begin
					r.out_valid = 1'b1;
					r.out_value = mach_regs[it.reg_x];
					mach_pc = mach_pc + tme_pkg::NPC_W'(tme_pkg::PC_STEP);
				end
				tme_pkg::OP_HALT: begin
					mach_halted = 1'b1;
				end
				tme_pkg::OP_JUMP: begin
					mach_pc = {it.operand_z[tme_pkg::OPZ_W-1:2], 2'b00};
				end
				tme_pkg::OP_SKIP: begin
					mach_pc = mach_pc + ((mach_regs[0] == '0)
						? tme_pkg::NPC_W'(tme_pkg::PC_STEP_SKIP)
						: tme_pkg::NPC_W'(tme_pkg::PC_STEP));
				end
				default: begin
					mach_pc = mach_pc + tme_pkg::NPC_W'(tme_pkg::PC_STEP);
				end
			endcase
		end
		r.next_pc = mach_pc;
		r.halted = mach_halted;
		return r;
	endfunction

	function automatic instr_t make_instr(input logic [tme_pkg::OPC_W-1:0] op, input int x,
			input int y, input int z, input logic [tme_pkg::WORD_W-1:0] val);
		instr_t it;
		it.opcode = op;
		it.reg_x = tme_pkg::RIDX_W'(x);
		it.reg_y = tme_pkg::RIDX_W'(y);
		it.operand_z = tme_pkg::OPZ_W'(z);
		it.in_value = val;
		return it;
	endfunction

	// offer one item in bursts with random gaps; starts and ends on a falling edge
	task automatic send_instr(input instr_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = sender_gaps_off ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tdata <= tme_pkg::S_TDATA_W'({it.in_value, it.operand_z, it.reg_y, it.reg_x,
			it.opcode});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(execute_instr(it));
		if (burst_left > 0) begin
			burst_left--;
		end
		@(negedge clk);
	endtask

	// receiver stall pattern plus requested long hold-off
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			if (rx_phase_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_phase_left = $urandom_range(16, 96);
			end
			rx_phase_left--;
			case (rx_mode)
				RX_STREAM:   m_tready <= 1'b1;
				RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE:   m_tready <= ($urandom_range(0, 7) != 0);
				RX_PERIODIC: m_tready <= ((rx_phase_left % 5) < 2);
				default:     m_tready <= 1'b1;
			endcase
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		exec_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with no instruction pending: tdata %h tuser %h", m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[8:0] !== want.next_pc) begin
					$error("next_pc: expected %0d, actual %0d", want.next_pc, m_tdata[8:0]);
					fail_count++;
				end
				if (m_tuser[0] !== want.out_valid) begin
					$error("out_valid: expected %0b, actual %0b", want.out_valid, m_tuser[0]);
					fail_count++;
				end
				if (m_tdata[40:9] !== want.out_value) begin
					$error("out_value: expected %0d, actual %0d",
						$signed(want.out_value), $signed(m_tdata[40:9]));
					fail_count++;
				end
				if (m_tdata[41] !== want.halted) begin
					$error("halted: expected %0b, actual %0b", want.halted, m_tdata[41]);
					fail_count++;
				end
			end
		end
	end

	// register and data memory contents straight out of reset
	task automatic test_reset_values();
		send_instr(make_instr(tme_pkg::OP_OUTPUT, tme_pkg::REG_ONE_IDX, 0, 0, '0));
		send_instr(make_instr(tme_pkg::OP_OUTPUT, 0, 7, 511, WORD_ONES));
		send_instr(make_instr(tme_pkg::OP_LOAD, 1, 0, 15, '0));
		send_instr(make_instr(tme_pkg::OP_OUTPUT, 1, 0, 0, '0));
	endtask

	// add and subtract wrap at the word extremes, index masking on operand_z
	task automatic test_arith_wrap();
		send_instr(make_instr(tme_pkg::OP_INPUT, 1, 0, 0, WORD_MAX));
		send_instr(make_instr(tme_pkg::OP_INPUT, 2, 0, 0, tme_pkg::WORD_W'(1)));
		send_instr(make_instr(tme_pkg::OP_ADD, 3, 1, 'h1fa, '0));
		send_instr(make_instr(tme_pkg::OP_OUTPUT, 3, 0, 0, '0));
		send_instr(make_instr(tme_pkg::OP_INPUT, 4, 0, 0, WORD_MIN));
		send_instr(make_instr(tme_pkg::OP_SUB, 5, 4, 'h1fa, '0));
		send_instr(make_instr(tme_pkg::OP_OUTPUT, 5, 0, 0, '0));
		send_instr(make_instr(tme_pkg::OP_INPUT, 7, 0, 0, WORD_ONES));
		send_instr(make_instr(tme_pkg::OP_SUB, 0, 7, 'h1ff, '0));
	endtask

	// store and load with addresses beyond the data memory
	task automatic test_memory_index();
		send_instr(make_instr(tme_pkg::OP_STORE, 3, 0, 'h1f0, '0));
		send_instr(make_instr(tme_pkg::OP_LOAD, 6, 0, 'h010, '0));
		send_instr(make_instr(tme_pkg::OP_STORE, 7, 0, 'h1ff, '0));
		send_instr(make_instr(tme_pkg::OP_LOAD, 2, 0, 'h00f, '0));
		send_instr(make_instr(tme_pkg::OP_OUTPUT, 2, 0, 0, '0));
	endtask

	// jump rounding, pc wrap, both skip outcomes, unknown opcodes
	task automatic test_control_flow();
		send_instr(make_instr(tme_pkg::OP_JUMP, 0, 0, 'h1ff, '0));
		send_instr(make_instr(OP_UNUSED_ZERO, 7, 7, 'h1ff, WORD_ONES));
		send_instr(make_instr(tme_pkg::OP_SKIP, 0, 0, 0, '0));
		send_instr(make_instr(tme_pkg::OP_INPUT, 0, 0, 0, WORD_ONES));
		send_instr(make_instr(tme_pkg::OP_SKIP, 0, 0, 0, '0));
		send_instr(make_instr(tme_pkg::OP_JUMP, 0, 0, 3, '0));
		send_instr(make_instr(OP_UNUSED_FIRST, 1, 2, 5, WORD_MAX));
		send_instr(make_instr(OP_UNUSED_LAST, 3, 4, 6, WORD_MIN));
	endtask

	function automatic instr_t random_instr();
		instr_t it;
		logic [tme_pkg::OPC_W-1:0] known_ops [8];
		int sel;
		known_ops = '{tme_pkg::OP_LOAD, tme_pkg::OP_ADD, tme_pkg::OP_STORE, tme_pkg::OP_SUB,
			tme_pkg::OP_INPUT, tme_pkg::OP_OUTPUT, tme_pkg::OP_JUMP, tme_pkg::OP_SKIP};
		sel = $urandom_range(0, 99);
		if (sel < 3) begin
			it.opcode = OP_UNUSED_ZERO;
		end else if (sel < 7) begin
			it.opcode = tme_pkg::OPC_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
		end else begin
			it.opcode = known_ops[$urandom_range(0, 7)];
		end
		it.reg_x = tme_pkg::RIDX_W'($urandom_range(0, 7));
		it.reg_y = tme_pkg::RIDX_W'($urandom_range(0, 7));
		it.operand_z = tme_pkg::OPZ_W'($urandom_range(0, 511));
		case ($urandom_range(0, 11))
			0: it.in_value = '0;
			1: it.in_value = WORD_ONES;
			2: it.in_value = WORD_MAX;
			3: it.in_value = WORD_MIN;
			default: it.in_value = $urandom;
		endcase
		return it;
	endfunction

	// random programs; skips are often preceded by a clear of r0
	task automatic test_random_program(input int count);
		instr_t it;
		for (int n = 0; n < count; n++) begin
			sender_gaps_off = ((n / 200) % 3 == 2);
			it = random_instr();
			if (it.opcode == tme_pkg::OP_SKIP && $urandom_range(0, 1) == 1) begin
				send_instr(make_instr(tme_pkg::OP_INPUT, 0, $urandom_range(0, 7),
					$urandom_range(0, 511), '0));
			end
			send_instr(it);
		end
		sender_gaps_off = 1'b0;
	endtask

	// long receiver hold-off while items keep coming back to back
	task automatic test_backpressure();
		rx_hold = 60;
		sender_gaps_off = 1'b1;
		burst_left = 0;
		for (int n = 0; n < 24; n++) begin
			send_instr(random_instr());
		end
		sender_gaps_off = 1'b0;
	endtask

	// halt, then items that must be ignored
	task automatic test_halt();
		instr_t it;
		send_instr(make_instr(tme_pkg::OP_HALT, $urandom_range(0, 7), $urandom_range(0, 7),
			$urandom_range(0, 511), $urandom));
		send_instr(make_instr(tme_pkg::OP_OUTPUT, tme_pkg::REG_ONE_IDX, 0, 0, '0));
		send_instr(make_instr(tme_pkg::OP_JUMP, 0, 0, 'h100, '0));
		send_instr(make_instr(tme_pkg::OP_HALT, 0, 0, 0, '0));
		for (int n = 0; n < 8; n++) begin
			it = random_instr();
			send_instr(it);
		end
	endtask

	initial begin
		reset_machine();
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_arith_wrap();
		test_memory_index();
		test_control_flow();
		test_backpressure();
		test_random_program(RANDOM_ITEMS);
		test_halt();

		// drain outstanding results
		s_tvalid <= 1'b0;
		while (pending_results.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
